/* design/ustc_pkg.sv */
// ----------------------------------------------------------------------------
// ustc_pkg
// Shared types, constants and the microcode store for the Unix seconds to
// calendar converter.
// ----------------------------------------------------------------------------
package ustc_pkg;

  // Calendar constants
  localparam logic [31:0] SECS_PER_MIN     = 32'd60;
  localparam logic [31:0] SECS_PER_HOUR    = 32'd3600;
  localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
  localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
  localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
  localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
  localparam logic [11:0] SKIP_LEAP_YEAR   = 12'd2100;
  localparam logic [3:0]  LAST_MONTH_IDX   = 4'd11;

  // Micro-operations
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_YEAR  = 3'd1;
  localparam logic [2:0] OP_MONTH = 3'd2;
  localparam logic [2:0] OP_DIGIT = 3'd3;
  localparam logic [2:0] OP_EMIT  = 3'd4;

  // Sequencing conditions
  localparam logic [1:0] CND_NEXT  = 2'd0;  // advance
  localparam logic [1:0] CND_TAKEN = 2'd1;  // jump when the subtract is taken
  localparam logic [1:0] CND_HOLD  = 2'd2;  // stay while stalled, else jump

  // Quotient destinations
  localparam logic [1:0] DST_NONE = 2'd0;
  localparam logic [1:0] DST_DAY  = 2'd1;
  localparam logic [1:0] DST_HOUR = 2'd2;
  localparam logic [1:0] DST_MIN  = 2'd3;

  // Program addresses
  localparam logic [4:0] STEP_LOAD  = 5'd0;
  localparam logic [4:0] STEP_YEAR  = 5'd1;
  localparam logic [4:0] STEP_MONTH = 5'd2;
  localparam logic [4:0] STEP_DAY0  = 5'd3;
  localparam logic [4:0] STEP_DAY4  = 5'd7;
  localparam logic [4:0] STEP_HOUR0 = 5'd8;
  localparam logic [4:0] STEP_HOUR4 = 5'd12;
  localparam logic [4:0] STEP_MIN0  = 5'd13;
  localparam logic [4:0] STEP_MIN5  = 5'd18;
  localparam logic [4:0] STEP_EMIT  = 5'd19;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] cond;
    logic [3:0] kidx;
    logic [1:0] dst;
    logic [4:0] jmp;
  } ucw_t;

  // Leap rule over the reachable years 1970..2106: the only century in
  // range that is not a leap year is 2100 (2000 is divisible by 400).
  function automatic logic is_leap(input logic [11:0] y);
    is_leap = (y[1:0] == 2'b00) && (y != SKIP_LEAP_YEAR);
  endfunction

  // Length of a month in seconds, index 0 is January.
  function automatic logic [31:0] month_span(input logic [3:0] m, input logic leap);
    case (m)
      4'd1:    month_span = leap ? 32'(29 * 86400) : 32'(28 * 86400);
      4'd3,
      4'd5,
      4'd8,
      4'd10:   month_span = 32'(30 * 86400);
      default: month_span = 32'(31 * 86400);
    endcase
  endfunction

  // Restoring-division weights: day bits 4..0, hour bits 4..0,
  // minute bits 5..0, most significant first.
  function automatic logic [31:0] digit_weight(input logic [3:0] k);
    case (k)
      4'd0:    digit_weight = SECS_PER_DAY << 4;
      4'd1:    digit_weight = SECS_PER_DAY << 3;
      4'd2:    digit_weight = SECS_PER_DAY << 2;
      4'd3:    digit_weight = SECS_PER_DAY << 1;
      4'd4:    digit_weight = SECS_PER_DAY;
      4'd5:    digit_weight = SECS_PER_HOUR << 4;
      4'd6:    digit_weight = SECS_PER_HOUR << 3;
      4'd7:    digit_weight = SECS_PER_HOUR << 2;
      4'd8:    digit_weight = SECS_PER_HOUR << 1;
      4'd9:    digit_weight = SECS_PER_HOUR;
      4'd10:   digit_weight = SECS_PER_MIN << 5;
      4'd11:   digit_weight = SECS_PER_MIN << 4;
      4'd12:   digit_weight = SECS_PER_MIN << 3;
      4'd13:   digit_weight = SECS_PER_MIN << 2;
      4'd14:   digit_weight = SECS_PER_MIN << 1;
      default: digit_weight = SECS_PER_MIN;
    endcase
  endfunction

  // Microcode store
  function automatic ucw_t ucode(input logic [4:0] pc);
    ucw_t w;
    w = '{op: OP_EMIT, cond: CND_HOLD, kidx: 4'd0, dst: DST_NONE, jmp: STEP_LOAD};
    case (pc) inside
      STEP_LOAD: begin
        w.op   = OP_LOAD;
        w.cond = CND_HOLD;
        w.jmp  = STEP_YEAR;
      end
      STEP_YEAR: begin
        w.op   = OP_YEAR;
        w.cond = CND_TAKEN;
        w.jmp  = STEP_YEAR;
      end
      STEP_MONTH: begin
        w.op   = OP_MONTH;
        w.cond = CND_TAKEN;
        w.jmp  = STEP_MONTH;
      end
      [STEP_DAY0:STEP_DAY4]: begin
        w.op   = OP_DIGIT;
        w.cond = CND_NEXT;
        w.dst  = DST_DAY;
        w.kidx = 4'(pc - STEP_DAY0);
      end
      [STEP_HOUR0:STEP_HOUR4]: begin
        w.op   = OP_DIGIT;
        w.cond = CND_NEXT;
        w.dst  = DST_HOUR;
        w.kidx = 4'(pc - STEP_DAY0);
      end
      [STEP_MIN0:STEP_MIN5]: begin
        w.op   = OP_DIGIT;
        w.cond = CND_NEXT;
        w.dst  = DST_MIN;
        w.kidx = 4'(pc - STEP_DAY0);
      end
      default: begin
        w.op   = OP_EMIT;
        w.cond = CND_HOLD;
        w.jmp  = STEP_LOAD;
      end
    endcase
    ucode = w;
  endfunction

endpackage

/* design/unix_seconds_to_calendar.sv */
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Converts a 32-bit Unix time to a Gregorian UTC date and time of day with a
// small microcoded sequencer over one shared compare-and-subtract datapath.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   input     in_valid / in_ready   in_epoch_seconds[31:0]
//   output    out_valid / out_ready out_year_out .. out_second_out
//
// The year walk strips one year per cycle.
// The next item is taken while a result waits in the output register.
// Reset (rst_n low, synchronous) returns the sequencer to its load step and
// empties the output register. A stalled output holds the emit step.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar
  import ustc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out
);

  // Sequencer and datapath state
  logic [4:0]  pc_r, pc_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  dayq_r, dayq_nxt;
  logic [4:0]  hourq_r, hourq_nxt;
  logic [5:0]  minq_r, minq_nxt;

  // Output register
  logic        ovld_r, ovld_nxt;
  logic [11:0] oyear_r, oyear_nxt;
  logic [3:0]  omonth_r, omonth_nxt;
  logic [4:0]  oday_r, oday_nxt;
  logic [4:0]  ohour_r, ohour_nxt;
  logic [5:0]  omin_r, omin_nxt;
  logic [5:0]  osec_r, osec_nxt;

  ucw_t        cw;
  logic [31:0] weight;
  logic        ge;
  logic        taken;
  logic        stall;
  logic        out_busy;

  assign cw       = ucode(pc_r);
  assign out_busy = ovld_r && !out_ready;
  assign in_ready = (cw.op == OP_LOAD);

  // Pick the weight for the shared compare-and-subtract
  always_comb begin
    case (cw.op)
      OP_YEAR:  weight = is_leap(year_r) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
      OP_MONTH: weight = month_span(month_r, is_leap(year_r));
      default:  weight = digit_weight(cw.kidx);
    endcase
  end

  assign ge = (rem_r >= weight);

  always_comb begin
    case (cw.op)
      OP_YEAR, OP_DIGIT: taken = ge;
      OP_MONTH:          taken = ge && (month_r < LAST_MONTH_IDX);
      default:           taken = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.op)
      OP_LOAD: stall = !in_valid;
      OP_EMIT: stall = out_busy;
      default: stall = 1'b0;
    endcase
  end

  // Advance the step counter
  always_comb begin
    case (cw.cond)
      CND_TAKEN: pc_nxt = taken ? cw.jmp : pc_r + 5'd1;
      CND_HOLD:  pc_nxt = stall ? pc_r : cw.jmp;
      default:   pc_nxt = pc_r + 5'd1;
    endcase
  end

  // Datapath updates
  always_comb begin
    rem_nxt   = rem_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    dayq_nxt  = dayq_r;
    hourq_nxt = hourq_r;
    minq_nxt  = minq_r;
    case (cw.op)
      OP_LOAD: begin
        if (in_valid) begin
          rem_nxt   = in_epoch_seconds;
          year_nxt  = EPOCH_YEAR;
          month_nxt = 4'd0;
          dayq_nxt  = 5'd0;
          hourq_nxt = 5'd0;
          minq_nxt  = 6'd0;
        end
      end
      OP_YEAR: begin
        if (taken) begin
          rem_nxt  = rem_r - weight;
          year_nxt = year_r + 12'd1;
        end
      end
      OP_MONTH: begin
        if (taken) begin
          rem_nxt   = rem_r - weight;
          month_nxt = month_r + 4'd1;
        end
      end
      OP_DIGIT: begin
        if (taken) begin
          rem_nxt = rem_r - weight;
        end
        case (cw.dst)
          DST_DAY:  dayq_nxt  = {dayq_r[3:0], taken};
          DST_HOUR: hourq_nxt = {hourq_r[3:0], taken};
          DST_MIN:  minq_nxt  = {minq_r[4:0], taken};
          default:  ;
        endcase
      end
      default: ;
    endcase
  end

  // Load the output register on the emit step, drop it on a taken beat
  always_comb begin
    ovld_nxt   = ovld_r && !out_ready;
    oyear_nxt  = oyear_r;
    omonth_nxt = omonth_r;
    oday_nxt   = oday_r;
    ohour_nxt  = ohour_r;
    omin_nxt   = omin_r;
    osec_nxt   = osec_r;
    if ((cw.op == OP_EMIT) && !out_busy) begin
      ovld_nxt   = 1'b1;
      oyear_nxt  = year_r;
      omonth_nxt = month_r + 4'd1;
      oday_nxt   = dayq_r + 5'd1;
      ohour_nxt  = hourq_r;
      omin_nxt   = minq_r;
      osec_nxt   = rem_r[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= STEP_LOAD;
      ovld_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    dayq_r   <= dayq_nxt;
    hourq_r  <= hourq_nxt;
    minq_r   <= minq_nxt;
    oyear_r  <= oyear_nxt;
    omonth_r <= omonth_nxt;
    oday_r   <= oday_nxt;
    ohour_r  <= ohour_nxt;
    omin_r   <= omin_nxt;
    osec_r   <= osec_nxt;
  end

  assign out_valid      = ovld_r;
  assign out_year_out   = oyear_r;
  assign out_month_out  = omonth_r;
  assign out_day_out    = oday_r;
  assign out_hour_out   = ohour_r;
  assign out_minute_out = omin_r;
  assign out_second_out = osec_r;

endmodule

/* design/ustc_checker.sv */
// ----------------------------------------------------------------------------
// ustc_checker
// Port-level checks for the Unix seconds to calendar converter.
// ----------------------------------------------------------------------------
module ustc_checker
  import ustc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_epoch_seconds,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_year_out,
  input logic [3:0]  out_month_out,
  input logic [4:0]  out_day_out,
  input logic [4:0]  out_hour_out,
  input logic [5:0]  out_minute_out,
  input logic [5:0]  out_second_out
);

  // Hold a waiting input beat
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_epoch_seconds))
    else $error("input beat changed while waiting");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year_out) &&
      $stable(out_month_out) && $stable(out_day_out) && $stable(out_hour_out) &&
      $stable(out_minute_out) && $stable(out_second_out))
    else $error("result beat changed while stalled");

  // Year and month stay in calendar range
  a_year_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_year_out >= EPOCH_YEAR && out_year_out <= 12'd2106 &&
      out_month_out >= 4'd1 && out_month_out <= 4'd12)
    else $error("year or month out of range");

  // Day fits its month
  a_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_day_out >= 5'd1 &&
      !(out_month_out == 4'd2 && out_day_out > 5'd29) &&
      !((out_month_out == 4'd4 || out_month_out == 4'd6 || out_month_out == 4'd9 ||
         out_month_out == 4'd11) && out_day_out > 5'd30))
    else $error("day does not fit month");

  // Time of day stays in range
  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hour_out <= 5'd23 && out_minute_out <= 6'd59 &&
      out_second_out <= 6'd59)
    else $error("time of day out of range");

endmodule

bind unix_seconds_to_calendar ustc_checker u_ustc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_epoch_seconds (in_epoch_seconds),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_year_out     (out_year_out),
  .out_month_out    (out_month_out),
  .out_day_out      (out_day_out),
  .out_hour_out     (out_hour_out),
  .out_minute_out   (out_minute_out),
  .out_second_out   (out_second_out)
);

/* dv/unix_seconds_to_calendar_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_tb
// Drives Unix second counts into the converter and checks every date and time
// that comes back against a behavioral calendar computed here. A directed set
// covers the range ends, leap and century years and month ends; random counts
// then favor year, month and day edges. Both channels idle at random.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_tb
  import ustc_pkg::*;
();

  localparam int RANDOM_BEATS = 750;
  localparam int MAX_IDLE     = 12;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  // Expected calendar dates, oldest first, and the checks against them
  class calendar_board;
    cal_t due_dates[$];
    int   errors;

    function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned month_days(int unsigned m, bit leap);
      case (m)
        1:          return leap ? 29 : 28;
        3, 5, 8, 10: return 30;
        default:    return 31;
      endcase
    endfunction

    function int unsigned year_secs(int unsigned y);
      return (leap_year(y) ? 366 : 365) * SECS_PER_DAY;
    endfunction

    // Seconds at the first instant of month m (0 = January) of year y, wrapped
    function logic [31:0] month_start(int unsigned y, int unsigned m);
      longint unsigned acc;
      acc = 0;
      for (int unsigned k = EPOCH_YEAR; k < y; k++) acc += year_secs(k);
      for (int unsigned j = 0; j < m; j++) acc += month_days(j, leap_year(y)) * SECS_PER_DAY;
      return 32'(acc);
    endfunction

    function cal_t to_calendar(logic [31:0] secs);
      logic [31:0] rest;
      int unsigned yr;
      int unsigned mo;
      bit          leap;
      cal_t        c;
      rest = secs;
      yr   = EPOCH_YEAR;
      mo   = 0;
      // Strip whole years, then whole months up to December
      while (rest >= year_secs(yr)) begin
        rest -= year_secs(yr);
        yr++;
      end
      leap = leap_year(yr);
      while (mo < 11 && rest >= month_days(mo, leap) * SECS_PER_DAY) begin
        rest -= month_days(mo, leap) * SECS_PER_DAY;
        mo++;
      end
      c.year   = 12'(yr);
      c.month  = 4'(mo + 1);
      c.day    = 5'(rest / SECS_PER_DAY + 1);
      rest     = rest % SECS_PER_DAY;
      c.hour   = 5'(rest / SECS_PER_HOUR);
      rest     = rest % SECS_PER_HOUR;
      c.minute = 6'(rest / SECS_PER_MIN);
      c.second = 6'(rest % SECS_PER_MIN);
      return c;
    endfunction

    function void note(logic [31:0] secs);
      due_dates.push_back(to_calendar(secs));
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check(cal_t got);
      cal_t want;
      if (due_dates.size() == 0) begin
        $error("result beat with no date expected");
        errors++;
        return;
      end
      want = due_dates.pop_front();
      field_check("year_out", want.year, got.year);
      field_check("month_out", want.month, got.month);
      field_check("day_out", want.day, got.day);
      field_check("hour_out", want.hour, got.hour);
      field_check("minute_out", want.minute, got.minute);
      field_check("second_out", want.second, got.second);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_year_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;
  logic [4:0]  out_hour_out;
  logic [5:0]  out_minute_out;
  logic [5:0]  out_second_out;

  calendar_board board = new;
  bit            send_idle = 1'b1;
  bit            take_idle = 1'b1;
  int            cycle_count = 0;

  unix_seconds_to_calendar uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_hour_out     (out_hour_out),
    .out_minute_out   (out_minute_out),
    .out_second_out   (out_second_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one count and hold it until the beat is taken
  task automatic send_seconds(input logic [31:0] secs);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    board.note(secs);
  endtask

  // Mostly land near year, month and day edges; the rest is uniform
  function automatic logic [31:0] random_seconds();
    logic [31:0] jitter;
    jitter = 32'($urandom_range(0, 8)) - 32'd4;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return board.month_start($urandom_range(1970, 2106), 0) + jitter;
      2: return board.month_start($urandom_range(1970, 2106), $urandom_range(0, 11)) + jitter;
      default: return SECS_PER_DAY * $urandom_range(0, 49710) +
                      ($urandom_range(0, 1) ? $urandom_range(0, 2)
                                            : SECS_PER_DAY - 1 - $urandom_range(0, 2));
    endcase
  endfunction

  // Accept result beats and check them
  initial begin
    int   stall;
    cal_t got;
    wait (rst_n === 1'b1);
    forever begin
      stall = take_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if ($urandom_range(0, 39) == 0) take_idle = !take_idle;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{out_year_out, out_month_out, out_day_out,
              out_hour_out, out_minute_out, out_second_out};
      board.check(got);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Range ends and time-of-day edges
    send_seconds(32'd0);
    send_seconds(32'd1);
    send_seconds(32'd59);
    send_seconds(32'd60);
    send_seconds(32'd3599);
    send_seconds(32'd3600);
    send_seconds(32'd86399);
    send_seconds(32'd86400);
    send_seconds(32'hFFFF_FFFF);
    send_seconds(32'hFFFF_FFFE);
    send_seconds(32'h8000_0000);
    send_seconds(32'h7FFF_FFFF);
    send_seconds(32'h5555_5555);
    send_seconds(32'hAAAA_AAAA);
    // December 31 of a common year, then the new year
    send_seconds(board.month_start(1971, 0) - 1);
    send_seconds(board.month_start(1971, 0));
    // Leap day and the last day of a leap year, where the year walk stops short
    send_seconds(board.month_start(1972, 1) + 28 * SECS_PER_DAY);
    send_seconds(board.month_start(1972, 11) + 30 * SECS_PER_DAY);
    send_seconds(board.month_start(1973, 0) - 1);
    // 2000 is a leap year, 2100 is not
    send_seconds(board.month_start(2000, 1) + 28 * SECS_PER_DAY + 43200);
    send_seconds(board.month_start(2001, 0) - 1);
    send_seconds(board.month_start(2100, 2) - 1);
    send_seconds(board.month_start(2100, 2));
    send_seconds(board.month_start(2106, 0));

    repeat (RANDOM_BEATS) send_seconds(random_seconds());
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for any stray beat
    while (board.due_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.due_dates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* unix_seconds_to_calendar.f */
design/ustc_pkg.sv
design/unix_seconds_to_calendar.sv
design/ustc_checker.sv
dv/unix_seconds_to_calendar_tb.sv
